FILE: design/tlpr_pkg.sv
// Shared codes for the two-list page reclaim block.
`default_nettype none
package tlpr_pkg;

  typedef enum logic [1:0] {
    LIST_FREE     = 2'd0,
    LIST_INACTIVE = 2'd1,
    LIST_ACTIVE   = 2'd2
  } list_e;

  typedef enum logic [1:0] {
    REC_UNMAPPED = 2'd0,
    REC_FRESH    = 2'd1,
    REC_MAPPED   = 2'd2,
    REC_REMOTE   = 2'd3
  } rec_e;

  typedef enum logic [2:0] {
    ACT_WRITE_BACK = 3'd0,
    ACT_CLEAN_DROP = 3'd1,
    ACT_DISCARD    = 3'd2,
    ACT_ZERO_FILL  = 3'd3,
    ACT_READ_IN    = 3'd4,
    ACT_ERROR      = 3'd5
  } act_e;

  typedef enum logic {
    CMD_FAULT  = 1'b0,
    CMD_ACCESS = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_SLOTS = 1'b0,
    CFG_HEAP  = 1'b1
  } cfg_reg_e;

  localparam int unsigned ACT_W   = 3;
  localparam int unsigned OSLOT_W = 6;
  localparam int unsigned OPAGE_W = 12;

endpackage
`default_nettype wire

FILE: design/tlpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tlpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: design/two_list_page_reclaim_top.sv
// Two-list page reclaim: slot pool with inactive/active lists and page records.
//
// Input stream (s_axis): one transfer is a page fault (tuser 0) or an access
// event (tuser 1). Output stream (m_axis): eviction reports followed by one
// final report (tlast) per fault; access events give no output.
// Config channel (cfg_*): index 0 sets slots in use and rebuilds the pool,
// index 1 sets the heap size in pages. cfg_ready_o is high only while the
// block is idle or clearing; s_axis_tready drops while cfg_valid_i is high.
//
// A fault that must reclaim moves or evicts slots from the lists before its
// final report; each slot step is a chain of read-modify-write passes over the
// single port pair of the slot memory.
// Items are taken one at a time; s_axis_tready is high only between items.
//
// Reset, and every write of index 0, starts a clearing pass that walks
// max(HEAP_PAGES, SLOTS) entries, one per cycle (4096 by default), while no
// item is taken. A stalled receiver holds the output register; the block
// then waits before its next report but keeps all state intact.
`default_nettype none
module two_list_page_reclaim_top
  import tlpr_pkg::*;
#(
  parameter int unsigned SLOTS              = 64,
  parameter int unsigned HEAP_PAGES         = 4096,
  parameter int unsigned RECLAIM_BATCH_SIZE = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [19:0] page_number, [25:20] slot_number, [26] is_write, [31:27] zero
  input  wire logic [31:0] s_axis_tdata,
  // [0] command
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [5:0] slot, [17:6] page, [23:18] zero
  output logic [23:0]      m_axis_tdata,
  // [2:0] action
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [12:0] cfg_data_i
);

  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned PW    = $clog2(HEAP_PAGES);
  localparam int unsigned CNW   = $clog2(SLOTS + 1);
  localparam int unsigned GW    = $clog2(RECLAIM_BATCH_SIZE + 1);
  localparam int unsigned CLR_N = (HEAP_PAGES > SLOTS) ? HEAP_PAGES : SLOTS;
  localparam int unsigned CLW   = $clog2(CLR_N);

  typedef struct packed {
    logic [PW-1:0] page;
    logic          acc;
    logic          dirty;
    list_e         lst;
    logic [SW-1:0] nxt;
    logic [SW-1:0] prv;
  } slot_ent_t;

  localparam int unsigned SLW = $bits(slot_ent_t);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ACC, S_F_CHK, S_F_REC, S_R_START, S_SI_TOP, S_SA_TOP,
    S_LAST_TOP, S_DEC, S_EV_REC, S_UL, S_PV_WR, S_NX_WR, S_PUSH, S_PH_WR,
    S_PUSH_FIN, S_EV_FIN, S_NEXT, S_F_POP, S_F_POP2, S_F_FIN, S_EMIT
  } state_e;

  typedef enum logic [1:0] {J_MOVE, J_EVICT, J_PLACE} job_e;
  typedef enum logic [1:0] {C_SI, C_SA, C_LAST} ctx_e;

  function automatic logic [CNW-1:0] sat_slots(input logic [6:0] v);
    logic [CNW-1:0] r;
    if (v == 7'd0) begin
      r = CNW'(1);
    end else if (32'(v) > SLOTS) begin
      r = CNW'(SLOTS);
    end else begin
      r = CNW'(v);
    end
    return r;
  endfunction

  state_e         state_q, ret_q;
  job_e           job_q;
  ctx_e           ctx_q;
  logic           second_q;
  logic [CLW-1:0] clr_q;
  logic [6:0]     slots_q;
  logic [12:0]    heap_q;
  logic [19:0]    page_q;
  logic           wr_q;
  rec_e           rec_q;
  logic [SW-1:0]  cur_q, old_q;
  slot_ent_t      e_q;
  list_e          tgt_q;
  logic [GW-1:0]  got_q;
  logic [CNW-1:0] cnt_fr_q, cnt_in_q, cnt_ac_q;
  logic [SW-1:0]  hd_in_q, tl_in_q, hd_ac_q, tl_ac_q;
  act_e           res_act_q;
  logic [5:0]     res_slot_q;
  logic [11:0]    res_page_q;
  logic           res_last_q;
  logic           m_vld_q;
  act_e           m_act_q;
  logic [5:0]     m_slot_q;
  logic [11:0]    m_page_q;
  logic           m_last_q;

  logic          in_fire, cfg_fire, pool_wr;
  logic [19:0]   in_page;
  logic [5:0]    in_slot;
  logic          in_write;

  logic          slot_we;
  logic [SW-1:0] slot_waddr, slot_raddr;
  slot_ent_t     slot_wdata, slot_rd, tmp;
  slot_ent_t     dec_ent, pop_ent, push_ent;
  logic          rec_we;
  logic [PW-1:0] rec_waddr, rec_raddr;
  rec_e          rec_wdata, rec_rd;
  logic [1:0]    rec_rd_raw;
  logic          fs_we;
  logic [SW-1:0] fs_waddr, fs_raddr, fs_wdata, fs_rd;
  logic [SLW-1:0] slot_rd_raw;

  act_e           ev_act;
  rec_e           ev_rec;
  logic [CNW-1:0] ul_cnt;
  logic [SW-1:0]  ul_hd, ul_tl;
  logic           ul_mid;
  logic [CNW-1:0] ps_cnt;
  logic [SW-1:0]  ps_hd;
  logic           out_range;

  assign in_page  = s_axis_tdata[19:0];
  assign in_slot  = s_axis_tdata[25:20];
  assign in_write = s_axis_tdata[26];

  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = (state_q == S_IDLE) || (state_q == S_CLEAR);
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign pool_wr       = cfg_fire && (cfg_index_i == CFG_SLOTS);

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {6'd0, m_page_q, m_slot_q};
  assign m_axis_tuser  = m_act_q;
  assign m_axis_tlast  = m_last_q;

  assign slot_rd = slot_ent_t'(slot_rd_raw);
  assign rec_rd  = rec_e'(rec_rd_raw);

  assign out_range = ({12'd0, page_q} >= 32'(heap_q)) || ({12'd0, page_q} >= 32'(HEAP_PAGES));

  // Eviction outcome from the dirty mark and the page record
  always_comb begin
    if (e_q.dirty) begin
      ev_act = ACT_WRITE_BACK;
      ev_rec = REC_REMOTE;
    end else if (rec_rd == REC_MAPPED) begin
      ev_act = ACT_CLEAN_DROP;
      ev_rec = REC_REMOTE;
    end else begin
      ev_act = ACT_DISCARD;
      ev_rec = REC_UNMAPPED;
    end
  end

  always_comb begin
    if (e_q.lst == LIST_ACTIVE) begin
      ul_cnt = cnt_ac_q;
      ul_hd  = hd_ac_q;
      ul_tl  = tl_ac_q;
    end else begin
      ul_cnt = cnt_in_q;
      ul_hd  = hd_in_q;
      ul_tl  = tl_in_q;
    end
    ul_mid = (ul_cnt > CNW'(1)) && (ul_hd != cur_q) && (ul_tl != cur_q);
    if (tgt_q == LIST_ACTIVE) begin
      ps_cnt = cnt_ac_q;
      ps_hd  = hd_ac_q;
    end else begin
      ps_cnt = cnt_in_q;
      ps_hd  = hd_in_q;
    end
  end

  // Next slot entry images for the decode, pop and push steps
  always_comb begin
    dec_ent     = slot_rd;
    dec_ent.acc = 1'b0;
    pop_ent      = '0;
    pop_ent.page = page_q[PW-1:0];
    pop_ent.lst  = LIST_FREE;
    push_ent     = e_q;
    push_ent.lst = tgt_q;
    if (ps_cnt != '0) begin
      push_ent.nxt = ps_hd;
    end
  end

  // Memory port control
  always_comb begin
    slot_raddr = cur_q;
    unique case (state_q)
      S_IDLE:                slot_raddr = SW'(in_slot);
      S_SI_TOP:              slot_raddr = tl_in_q;
      S_SA_TOP, S_LAST_TOP:  slot_raddr = tl_ac_q;
      S_UL:                  slot_raddr = e_q.prv;
      S_PV_WR:               slot_raddr = e_q.nxt;
      S_PUSH:                slot_raddr = ps_hd;
      default:               slot_raddr = cur_q;
    endcase

    tmp        = slot_rd;
    slot_we    = 1'b0;
    slot_waddr = cur_q;
    slot_wdata = e_q;
    unique case (state_q)
      S_CLEAR: begin
        slot_we    = 32'(clr_q) < SLOTS;
        slot_waddr = SW'(clr_q);
        tmp        = '0;
        tmp.lst    = LIST_FREE;
        slot_wdata = tmp;
      end
      S_ACC: begin
        slot_we    = slot_rd.lst != LIST_FREE;
        tmp.acc    = 1'b1;
        tmp.dirty  = slot_rd.dirty | wr_q;
        slot_wdata = tmp;
      end
      S_PV_WR: begin
        slot_we    = 1'b1;
        slot_waddr = e_q.prv;
        tmp.nxt    = e_q.nxt;
        slot_wdata = tmp;
      end
      S_NX_WR: begin
        slot_we    = 1'b1;
        slot_waddr = e_q.nxt;
        tmp.prv    = e_q.prv;
        slot_wdata = tmp;
      end
      S_PH_WR: begin
        slot_we    = 1'b1;
        slot_waddr = old_q;
        tmp.prv    = cur_q;
        slot_wdata = tmp;
      end
      S_PUSH_FIN: begin
        slot_we = 1'b1;
      end
      S_EV_FIN: begin
        slot_we    = 1'b1;
        tmp        = e_q;
        tmp.acc    = 1'b0;
        tmp.dirty  = 1'b0;
        slot_wdata = tmp;
      end
      default: slot_we = 1'b0;
    endcase

    rec_raddr = (state_q == S_DEC) ? slot_rd.page : page_q[PW-1:0];
    rec_we    = 1'b0;
    rec_waddr = page_q[PW-1:0];
    rec_wdata = REC_UNMAPPED;
    unique case (state_q)
      S_CLEAR: begin
        rec_we    = 32'(clr_q) < HEAP_PAGES;
        rec_waddr = PW'(clr_q);
      end
      S_EV_REC: begin
        rec_we    = 1'b1;
        rec_waddr = e_q.page;
        rec_wdata = ev_rec;
      end
      S_F_FIN: begin
        rec_we    = 1'b1;
        rec_wdata = (rec_q == REC_UNMAPPED) ? REC_FRESH : REC_MAPPED;
      end
      default: rec_we = 1'b0;
    endcase

    fs_raddr = SW'(cnt_fr_q - CNW'(1));
    fs_we    = 1'b0;
    fs_waddr = SW'(cnt_fr_q);
    fs_wdata = cur_q;
    unique case (state_q)
      S_CLEAR: begin
        fs_we    = 32'(clr_q) < SLOTS;
        fs_waddr = SW'(clr_q);
        fs_wdata = SW'(clr_q);
      end
      S_EV_FIN: fs_we = 32'(cnt_fr_q) < SLOTS;
      default:  fs_we = 1'b0;
    endcase
  end

  tlpr_ram #(.WIDTH(SLW), .DEPTH(SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rd_raw)
  );

  tlpr_ram #(.WIDTH(2), .DEPTH(HEAP_PAGES)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rd_raw)
  );

  tlpr_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      ret_q      <= S_IDLE;
      job_q      <= J_MOVE;
      ctx_q      <= C_SI;
      second_q   <= 1'b0;
      clr_q      <= '0;
      slots_q    <= 7'd64;
      heap_q     <= 13'd4096;
      page_q     <= '0;
      wr_q       <= 1'b0;
      rec_q      <= REC_UNMAPPED;
      cur_q      <= '0;
      old_q      <= '0;
      e_q        <= '0;
      tgt_q      <= LIST_INACTIVE;
      got_q      <= '0;
      cnt_fr_q   <= sat_slots(7'd64);
      cnt_in_q   <= '0;
      cnt_ac_q   <= '0;
      hd_in_q    <= '0;
      tl_in_q    <= '0;
      hd_ac_q    <= '0;
      tl_ac_q    <= '0;
      res_act_q  <= ACT_ERROR;
      res_slot_q <= '0;
      res_page_q <= '0;
      res_last_q <= 1'b0;
      m_vld_q    <= 1'b0;
      m_act_q    <= ACT_ERROR;
      m_slot_q   <= '0;
      m_page_q   <= '0;
      m_last_q   <= 1'b0;
    end else begin
      if (m_axis_tready && state_q != S_EMIT) begin
        m_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          if (pool_wr) begin
            slots_q  <= cfg_data_i[6:0];
            cnt_fr_q <= sat_slots(cfg_data_i[6:0]);
            cnt_in_q <= '0;
            cnt_ac_q <= '0;
            clr_q    <= '0;
          end else begin
            clr_q <= clr_q + CLW'(1);
            if (clr_q == CLW'(CLR_N - 1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (pool_wr) begin
            // Rebuild the pool
            slots_q  <= cfg_data_i[6:0];
            cnt_fr_q <= sat_slots(cfg_data_i[6:0]);
            cnt_in_q <= '0;
            cnt_ac_q <= '0;
            clr_q    <= '0;
            state_q  <= S_CLEAR;
          end else if (in_fire) begin
            page_q <= in_page;
            wr_q   <= in_write;
            cur_q  <= SW'(in_slot);
            if (s_axis_tuser == CMD_ACCESS) begin
              // Slot numbers beyond the pool are ignored
              if (32'(in_slot) < SLOTS) begin
                state_q <= S_ACC;
              end
            end else begin
              state_q <= S_F_CHK;
            end
          end
        end
        S_ACC: state_q <= S_IDLE;
        S_F_CHK: begin
          res_act_q  <= ACT_ERROR;
          res_slot_q <= '0;
          res_page_q <= page_q[11:0];
          res_last_q <= 1'b1;
          ret_q      <= S_IDLE;
          state_q    <= out_range ? S_EMIT : S_F_REC;
        end
        S_F_REC: begin
          rec_q <= rec_rd;
          if (rec_rd == REC_FRESH || rec_rd == REC_MAPPED) begin
            state_q <= S_EMIT;
          end else if (cnt_fr_q == '0) begin
            state_q <= S_R_START;
          end else begin
            state_q <= S_F_POP;
          end
        end
        S_R_START: begin
          got_q    <= '0;
          second_q <= 1'b0;
          if (cnt_in_q == '0) begin
            ctx_q   <= C_SA;
            state_q <= S_SA_TOP;
          end else begin
            ctx_q   <= C_SI;
            state_q <= S_SI_TOP;
          end
        end
        S_SI_TOP: begin
          if (got_q < GW'(RECLAIM_BATCH_SIZE) && cnt_in_q != '0) begin
            cur_q   <= tl_in_q;
            state_q <= S_DEC;
          end else if (!second_q && got_q < GW'(RECLAIM_BATCH_SIZE) && cnt_ac_q != '0) begin
            // Batch still short: demote the active list and scan again
            second_q <= 1'b1;
            ctx_q    <= C_SA;
            state_q  <= S_SA_TOP;
          end else begin
            ctx_q   <= C_LAST;
            state_q <= S_LAST_TOP;
          end
        end
        S_SA_TOP: begin
          if (cnt_ac_q != '0) begin
            cur_q   <= tl_ac_q;
            state_q <= S_DEC;
          end else begin
            ctx_q   <= C_SI;
            state_q <= S_SI_TOP;
          end
        end
        S_LAST_TOP: begin
          if (got_q < GW'(RECLAIM_BATCH_SIZE) && cnt_ac_q != '0) begin
            cur_q   <= tl_ac_q;
            state_q <= S_DEC;
          end else begin
            state_q <= S_F_POP;
          end
        end
        S_DEC: begin
          // Drop the accessed mark; an evicted slot loses it anyway
          e_q <= dec_ent;
          unique case (ctx_q)
            C_SI: begin
              if (slot_rd.acc) begin
                tgt_q   <= LIST_ACTIVE;
                job_q   <= J_MOVE;
                state_q <= S_UL;
              end else begin
                job_q   <= J_EVICT;
                state_q <= S_EV_REC;
              end
            end
            C_SA: begin
              tgt_q   <= slot_rd.acc ? LIST_ACTIVE : LIST_INACTIVE;
              job_q   <= J_MOVE;
              state_q <= S_UL;
            end
            default: begin
              job_q   <= J_EVICT;
              state_q <= S_EV_REC;
            end
          endcase
        end
        S_EV_REC: begin
          res_act_q <= ev_act;
          state_q   <= S_UL;
        end
        S_UL: begin
          e_q.lst <= LIST_FREE;
          if (e_q.lst == LIST_ACTIVE) begin
            if (cnt_ac_q <= CNW'(1)) begin
              cnt_ac_q <= '0;
            end else begin
              cnt_ac_q <= cnt_ac_q - CNW'(1);
              if (hd_ac_q == cur_q) begin
                hd_ac_q <= e_q.nxt;
              end else if (tl_ac_q == cur_q) begin
                tl_ac_q <= e_q.prv;
              end
            end
          end else begin
            if (cnt_in_q <= CNW'(1)) begin
              cnt_in_q <= '0;
            end else begin
              cnt_in_q <= cnt_in_q - CNW'(1);
              if (hd_in_q == cur_q) begin
                hd_in_q <= e_q.nxt;
              end else if (tl_in_q == cur_q) begin
                tl_in_q <= e_q.prv;
              end
            end
          end
          if (ul_mid) begin
            state_q <= S_PV_WR;
          end else begin
            state_q <= (job_q == J_EVICT) ? S_EV_FIN : S_PUSH;
          end
        end
        S_PV_WR: state_q <= S_NX_WR;
        S_NX_WR: state_q <= (job_q == J_EVICT) ? S_EV_FIN : S_PUSH;
        S_PUSH: begin
          e_q <= push_ent;
          if (ps_cnt == '0) begin
            state_q <= S_PUSH_FIN;
            if (tgt_q == LIST_ACTIVE) begin
              hd_ac_q <= cur_q;
              tl_ac_q <= cur_q;
            end else begin
              hd_in_q <= cur_q;
              tl_in_q <= cur_q;
            end
          end else begin
            old_q   <= ps_hd;
            state_q <= S_PH_WR;
            if (tgt_q == LIST_ACTIVE) begin
              hd_ac_q <= cur_q;
            end else begin
              hd_in_q <= cur_q;
            end
          end
          if (tgt_q == LIST_ACTIVE) begin
            cnt_ac_q <= cnt_ac_q + CNW'(1);
          end else begin
            cnt_in_q <= cnt_in_q + CNW'(1);
          end
        end
        S_PH_WR: state_q <= S_PUSH_FIN;
        S_PUSH_FIN: state_q <= (job_q == J_PLACE) ? S_F_FIN : S_NEXT;
        S_EV_FIN: begin
          if (32'(cnt_fr_q) < SLOTS) begin
            cnt_fr_q <= cnt_fr_q + CNW'(1);
          end
          got_q      <= got_q + GW'(1);
          res_slot_q <= 6'(cur_q);
          res_page_q <= 12'(e_q.page);
          res_last_q <= 1'b0;
          ret_q      <= S_NEXT;
          state_q    <= S_EMIT;
        end
        S_NEXT: begin
          unique case (ctx_q)
            C_SI:    state_q <= S_SI_TOP;
            C_SA:    state_q <= S_SA_TOP;
            default: state_q <= S_LAST_TOP;
          endcase
        end
        S_F_POP: begin
          if (cnt_fr_q == '0) begin
            res_act_q  <= ACT_ERROR;
            res_slot_q <= '0;
            res_page_q <= page_q[11:0];
            res_last_q <= 1'b1;
            ret_q      <= S_IDLE;
            state_q    <= S_EMIT;
          end else begin
            cnt_fr_q <= cnt_fr_q - CNW'(1);
            state_q  <= S_F_POP2;
          end
        end
        S_F_POP2: begin
          cur_q       <= fs_rd;
          e_q         <= pop_ent;
          tgt_q       <= LIST_INACTIVE;
          job_q       <= J_PLACE;
          state_q     <= S_PUSH;
        end
        S_F_FIN: begin
          res_act_q  <= (rec_q == REC_UNMAPPED) ? ACT_ZERO_FILL : ACT_READ_IN;
          res_slot_q <= 6'(cur_q);
          res_page_q <= page_q[11:0];
          res_last_q <= 1'b1;
          ret_q      <= S_IDLE;
          state_q    <= S_EMIT;
        end
        S_EMIT: begin
          // Hold until the output register is free
          if (!m_vld_q || m_axis_tready) begin
            m_vld_q  <= 1'b1;
            m_act_q  <= res_act_q;
            m_slot_q <= res_slot_q;
            m_page_q <= res_page_q;
            m_last_q <= res_last_q;
            state_q  <= ret_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cfg_fire && cfg_index_i == CFG_HEAP) begin
        heap_q <= cfg_data_i;
      end
    end
  end

`ifndef SYNTH
  a_slot_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cnt_fr_q) + 32'(cnt_in_q) + 32'(cnt_ac_q)) <= SLOTS)
    else $error("slot counts exceed pool size");

  a_batch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(got_q) <= RECLAIM_BATCH_SIZE)
    else $error("reclaim batch overshoot");

  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_fire && cfg_index_i == CFG_SLOTS) |=> (state_q == S_CLEAR))
    else $error("pool write did not start a clearing pass");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tuser == ACT_ZERO_FILL || m_axis_tuser == ACT_READ_IN ||
       m_axis_tuser == ACT_ERROR))
    else $error("final report is an eviction");

  a_slots_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cnt_fr_q == sat_slots(slots_q) ||
      (32'(cnt_fr_q) + 32'(cnt_in_q) + 32'(cnt_ac_q)) == 32'(sat_slots(slots_q))))
    else $error("slots lost from the pool");
`endif

endmodule
`default_nettype wire
